[rtl/indexed_ordered_list_assert.svh]
// assertion macros used by the list rtl
`ifndef INDEXED_ORDERED_LIST_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ASSERT_SVH

// expression holds on every clock outside reset
`define IOL_ASSERT_ALWAYS(label, clk_s, rst_s, expr) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) \
    else $error("list invariant violated");

// consequent holds in the same cycle as the antecedent
`define IOL_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("list same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define IOL_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("list next-cycle check failed");

`endif

[rtl/iol_pkg.sv]
package iol_pkg;

  // store geometry
  localparam int LIST_DEPTH = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // request from the control side to the store
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic [IDX_W-1:0]      position;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] word;
  } req_t;

  // completion from the store
  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] rdata;
  } rsp_t;

endpackage

[rtl/indexed_ordered_list.sv]
// Ordered list of up to 64 words. An operation is taken when start is high and
// busy is low; its one result word is on word_out, status and length for the
// single cycle in which done is high, and must be captured then: the block
// cannot be stalled by the receiver. Append, a read or remove past the end,
// an append to a full list, the unused operation code and the removal of the
// last word give their result in the cycle after acceptance. A read waits for
// the store's read state and the memory's registered read port. A remove with
// words behind the removed one shifts each down one slot through the memory's
// registered read port and its write port, one word per cycle. busy is low
// again in the cycle that done is shown. No clearing pass is needed after reset.
`include "indexed_ordered_list_assert.svh"

module indexed_ordered_list (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [iol_pkg::IDX_W-1:0]      position,
  input  logic [iol_pkg::DATA_WIDTH-1:0] word_in,
  output logic                           done,
  output logic [iol_pkg::DATA_WIDTH-1:0] word_out,
  output logic [1:0]                     status,
  output logic [iol_pkg::CNT_W-1:0]      length
);
  import iol_pkg::*;

  logic [CNT_W-1:0] item_count;
  logic [CNT_W-1:0] item_count_next;
  logic             pend_read;
  logic             accept;
  logic             full;
  logic             found;
  logic             has_tail;
  logic             wait_store;
  status_t          status_now;
  op_t              op;
  req_t             req;
  rsp_t             rsp;

  // decode the incoming word
  always_comb begin
    accept     = start && !busy;
    op         = op_t'(operation);
    full       = item_count == CNT_W'(LIST_DEPTH);
    found      = CNT_W'(position) < item_count;
    has_tail   = (CNT_W'(position) + CNT_W'(1)) < item_count;
    wait_store = 1'b0;
    status_now = ST_OK;
    item_count_next = item_count;
    req.valid  = 1'b0;
    case (op)
      OP_APPEND: begin
        if (full) begin
          status_now = ST_FULL;
        end else begin
          req.valid       = accept;
          item_count_next = item_count + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (found) begin
          req.valid  = accept;
          wait_store = 1'b1;
        end else begin
          status_now = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          item_count_next = item_count - CNT_W'(1);
          req.valid       = accept && has_tail;
          wait_store      = has_tail;
        end else begin
          status_now = ST_NOT_FOUND;
        end
      end
      default: status_now = ST_OK;
    endcase
    req.op       = op;
    req.position = position;
    req.count    = item_count;
    req.word     = word_in;
  end

  iol_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // count, busy flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      busy       <= 1'b0;
      done       <= 1'b0;
      pend_read  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        item_count <= item_count_next;
        pend_read  <= op == OP_READ;
        if (wait_store) begin
          busy <= 1'b1;
        end else begin
          done     <= 1'b1;
          word_out <= '0;
          status   <= status_now;
          length   <= item_count_next;
        end
      end else if (busy && rsp.done) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        word_out <= pend_read ? rsp.rdata : '0;
        status   <= ST_OK;
        length   <= item_count;
      end
    end
  end

  // checks
  `IOL_ASSERT_ALWAYS(a_count_bound, clk, rst, item_count <= CNT_W'(LIST_DEPTH))
  `IOL_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy)
  `IOL_ASSERT_NEXT(a_accept_progress, clk, rst, accept, done || busy)
  `IOL_ASSERT_SAME(a_store_done_busy, clk, rst, rsp.done, busy)

endmodule

[rtl/iol_store.sv]
module iol_store (
  input  logic         clk,
  input  logic         rst,
  input  iol_pkg::req_t req,
  output iol_pkg::rsp_t rsp
);
  import iol_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      shift_idx;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] mem [LIST_DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  last_step;

  // shift ends when the source of this step is the last held word
  always_comb begin
    last_step = (CNT_W'(shift_idx) + CNT_W'(2)) == cnt;
  end

  // read address: next source during a shift, else the requested slot (the one after it for a remove)
  always_comb begin
    case (state)
      S_SHIFT: rd_addr = shift_idx + IDX_W'(2);
      default: begin
        if (req.op == OP_REMOVE) begin
          rd_addr = req.position + IDX_W'(1);
        end else begin
          rd_addr = req.position;
        end
      end
    endcase
  end

  // write port: shifted word moves down one slot, or append at the tail
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = shift_idx;
    wr_data = rdata;
    case (state)
      S_SHIFT: wr_en = 1'b1;
      S_IDLE: begin
        if (req.valid && req.op == OP_APPEND) begin
          wr_en   = 1'b1;
          wr_addr = req.count[IDX_W-1:0];
          wr_data = req.word;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // word memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            case (req.op)
              OP_READ: state <= S_READ;
              OP_REMOVE: begin
                state     <= S_SHIFT;
                shift_idx <= req.position;
                cnt       <= req.count;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: state <= S_IDLE;
        S_SHIFT: begin
          if (last_step) begin
            state <= S_IDLE;
          end else begin
            shift_idx <= shift_idx + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // completion
  always_comb begin
    rsp.done  = (state == S_READ) || (state == S_SHIFT && last_step);
    rsp.rdata = rdata;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import iol_pkg::*;

  // one reply word as the list reports it
  typedef struct packed {
    logic [DATA_WIDTH-1:0] word;
    logic [1:0]            status;
    logic [CNT_W-1:0]      length;
  } reply_t;

  // shadow copy of the list and the replies it still owes
  class list_shadow;
    logic [DATA_WIDTH-1:0] words [LIST_DEPTH];
    int unsigned           held;
    reply_t                pending[$];
    int unsigned           failures;
    int unsigned           reports;

    function new();
      held     = 0;
      failures = 0;
      reports  = 0;
    endfunction

    // apply one accepted operation and queue the reply it must produce
    function void apply_op(op_t op, logic [IDX_W-1:0] pos, logic [DATA_WIDTH-1:0] w);
      reply_t rep;
      int     i;
      rep.word   = '0;
      rep.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (held >= LIST_DEPTH) begin
            rep.status = ST_FULL;
          end else begin
            words[held] = w;
            held++;
          end
        end
        OP_READ: begin
          if (pos >= held) rep.status = ST_NOT_FOUND;
          else rep.word = words[pos];
        end
        OP_REMOVE: begin
          if (pos >= held) begin
            rep.status = ST_NOT_FOUND;
          end else begin
            for (i = pos; i + 1 < held; i++) words[i] = words[i + 1];
            held--;
          end
        end
        default: ;
      endcase
      rep.length = held[CNT_W-1:0];
      pending.push_back(rep);
    endfunction

    function void report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      failures++;
      if (reports < 100) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        reports++;
      end
    endfunction

    // compare one reply word with the oldest owed reply
    function void check_reply(logic [DATA_WIDTH-1:0] w, logic [1:0] st, logic [CNT_W-1:0] len);
      reply_t rep;
      if (pending.size() == 0) begin
        failures++;
        if (reports < 100) begin
          $display("%0t: reply with nothing pending, actual word %0h status %0h length %0d",
                   $time, w, st, len);
          reports++;
        end
        return;
      end
      rep = pending.pop_front();
      if (w !== rep.word) report_field("word_out", 64'(rep.word), 64'(w));
      if (st !== rep.status) report_field("status", 64'(rep.status), 64'(st));
      if (len !== rep.length) report_field("length", 64'(rep.length), 64'(len));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [1:0]            operation = OP_IGNORE;
  logic [IDX_W-1:0]      position = '0;
  logic [DATA_WIDTH-1:0] word_in = '0;
  logic                  busy;
  logic                  done;
  logic [DATA_WIDTH-1:0] word_out;
  logic [1:0]            status;
  logic [CNT_W-1:0]      length;

  list_shadow  shadow = new();
  int unsigned sender_idle_pct = 23;

  indexed_ordered_list dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .position  (position),
    .word_in   (word_in),
    .done      (done),
    .word_out  (word_out),
    .status    (status),
    .length    (length)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst && done === 1'b1) shadow.check_reply(word_out, status, length);
  end

  // present one operation after a random idle gap and hold it until taken
  task automatic send_op(op_t op, logic [IDX_W-1:0] pos, logic [DATA_WIDTH-1:0] w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    position  <= pos;
    word_in   <= w;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.apply_op(op, pos, w);
  endtask

  // hold off until every owed reply has come back
  task automatic wait_replies();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending.size() != 0);
  endtask

  function automatic logic [DATA_WIDTH-1:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // position mostly inside the list, sometimes anywhere
  function automatic logic [IDX_W-1:0] rand_pos();
    if (shadow.held > 0 && $urandom_range(0, 9) < 8)
      return IDX_W'($urandom_range(0, shadow.held - 1));
    return IDX_W'($urandom_range(0, LIST_DEPTH - 1));
  endfunction

  // random operations with occasional fill-to-full and drain-to-empty runs
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        // fill until full, then push against the full store
        while (shadow.held < LIST_DEPTH) begin
          if ($urandom_range(0, 3) == 0) send_op(OP_READ, rand_pos(), rand_word());
          else send_op(OP_APPEND, IDX_W'($urandom), rand_word());
          sent++;
        end
        send_op(OP_APPEND, IDX_W'($urandom), rand_word());
        send_op(OP_READ, IDX_W'(LIST_DEPTH - 1), rand_word());
        send_op(OP_APPEND, IDX_W'($urandom), rand_word());
        sent += 3;
      end else if (pick == 1) begin
        // drain to empty, then poke the empty list
        while (shadow.held > 0) begin
          send_op(OP_REMOVE, IDX_W'($urandom_range(0, shadow.held - 1)), rand_word());
          sent++;
        end
        send_op(OP_REMOVE, IDX_W'($urandom), rand_word());
        send_op(OP_READ, IDX_W'($urandom), rand_word());
        sent += 2;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 36) send_op(OP_APPEND, IDX_W'($urandom), rand_word());
        else if (pick < 68) send_op(OP_READ, rand_pos(), rand_word());
        else if (pick < 94) send_op(OP_REMOVE, rand_pos(), rand_word());
        else send_op(OP_IGNORE, IDX_W'($urandom), rand_word());
        sent++;
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, past-the-end, head, middle and tail removal
    send_op(OP_READ, 0, '0);
    send_op(OP_REMOVE, 0, '1);
    send_op(OP_REMOVE, IDX_W'(LIST_DEPTH - 1), '0);
    send_op(OP_IGNORE, 0, 32'h1234_5678);
    send_op(OP_APPEND, IDX_W'(LIST_DEPTH - 1), '0);
    send_op(OP_APPEND, 0, '1);
    send_op(OP_APPEND, 6'h2a, 32'ha5a5_5a5a);
    send_op(OP_APPEND, 6'h15, 32'h0000_0001);
    send_op(OP_APPEND, 0, 32'h8000_0000);
    send_op(OP_READ, 0, '1);
    send_op(OP_READ, 1, '0);
    send_op(OP_READ, 4, '0);
    send_op(OP_READ, 5, '0);
    send_op(OP_READ, IDX_W'(LIST_DEPTH - 1), '0);
    send_op(OP_REMOVE, 5, '0);
    send_op(OP_REMOVE, 1, '0);
    send_op(OP_READ, 1, '0);
    send_op(OP_REMOVE, 3, '0);
    send_op(OP_REMOVE, 0, '0);
    send_op(OP_IGNORE, IDX_W'(LIST_DEPTH - 1), '1);
    send_op(OP_READ, 0, '0);
    send_op(OP_REMOVE, 1, '0);
    send_op(OP_REMOVE, 0, '0);
    send_op(OP_READ, 0, '0);
    wait_replies();

    // random phases with different sender idling
    run_random(410);
    wait_replies();
    sender_idle_pct = 59;
    run_random(410);
    wait_replies();
    sender_idle_pct = 0;
    run_random(410);

    // let everything drain, then watch for stray replies
    wait_replies();
    repeat (70) @(posedge clk);
    if (shadow.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/iol_pkg.sv
rtl/iol_store.sv
rtl/indexed_ordered_list.sv
dv/testbench.sv
